// File: rtl/gop_pkg.sv
// ----------------------------------------------------------------------------
// gop_pkg
// Shared constants for the Gamma(1+x) polynomial datapath: coefficient
// format and the signed fixed-point coefficient table.
// ----------------------------------------------------------------------------
package gop_pkg;

    localparam int unsigned MAX_TERMS      = 30;
    localparam int unsigned COEF_FRAC_BITS = 56;
    localparam int unsigned ACC_W          = 64;
    localparam int unsigned X_W            = 33;

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [X_W-1:0]   x_t;

    // Decimal scaling for the exact fractions (digits after the point)
    localparam logic [319:0] P62 = 320'd10 ** 62;
    localparam logic [319:0] P64 = 320'd10 ** 64;
    localparam logic [319:0] P65 = 320'd10 ** 65;
    localparam logic [319:0] P66 = 320'd10 ** 66;
    localparam logic [319:0] P67 = 320'd10 ** 67;

    // Each entry: round(fraction * 2^56), ties away from zero, then sign applied
    localparam acc_t COEF [MAX_TERMS] = '{
        acc_t'(64'd1 << COEF_FRAC_BITS),
        acc_t'(-64'((((320'd5772156649015328605867504180524819743117047335253698707946215782
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9890559953279725480567736016011074551731970227871841326147670037
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9074790760808853204034041123531852470048241450183333319688654403
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9817280868343342993508170961593701086734340526645559305830260364
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9819950689004158144339628200322199063804287933962962701660364352
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9931491145454546596782858789496350328652763778299599764441614315
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9960017589382732748089175162811376314697147473176727548253925349
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9981056715129189680990573784917422247740403929981223999668834399
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9990250134118399800372439103878567997541294491709751397892570239
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9995133628162019845482052880889581723670991136329077245238140199
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9997399284276842800847569140354098696960804838510334107125689736
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9997791255148989102928786523422115508693106406801813139004551520
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9994504397726759377378756316403384848980389881027808702884505848
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9979535245458726816208470913414942086863398570568581090328391650
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9929609973542025129822480482007778526218927585141017688579208531
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd9791739016563532773539533100165369613035793704671064296668045075
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd9471479549842206850430750762894205529764109064566593394834907327
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd8843618782148606539970266389247349247667405257184289291251064020
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd7804429582293780035462100559354943723915093847420921135949438237
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd6354645773560346047205100084882105703634791106498237509281422778
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd4655773241310680445401866356009338719839776846509169710182875371
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd2993245854990955480240411051361101341114304008683617635575278364
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd1646081873675282259931192131477486890184996839736595319623786902
            << 57) / P64) + 320'd1) >> 1)),
        acc_t'(64'((((320'd07531660607553232952371244924139683428299053155028415770684736347
            << 57) / P65) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd02774103935426569153750679132953790742164427656251619171270142394
            << 57) / P65) + 320'd1) >> 1)),
        acc_t'(64'((((320'd007871475255988880238358932061028742971085369173140485201668656701
            << 57) / P66) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd001610055659291006362895556315972035309013456479231051353987482957
            << 57) / P66) + 320'd1) >> 1)),
        acc_t'(64'((((320'd0002108086307668984701877376536205400787900905232817074763827402896
            << 57) / P67) + 320'd1) >> 1)),
        acc_t'(-64'((((320'd00001324627302460587650246889364226604892336483855819419952292
            << 57) / P62) + 320'd1) >> 1))
    };

endpackage

// File: rtl/gop_step.sv
// ----------------------------------------------------------------------------
// gop_step
// One Horner step over two register stages: acc*x/2^32 + coef.
// ----------------------------------------------------------------------------
module gop_step
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  gop_pkg::acc_t in_acc,
    input  gop_pkg::x_t   in_x,
    input  gop_pkg::acc_t coef,
    output logic          out_valid,
    output gop_pkg::acc_t out_acc,
    output gop_pkg::x_t   out_x
);
    import gop_pkg::*;

    logic                 va_reg;
    logic signed [64:0]   p_hi_reg;
    logic        [63:0]   p_lo_reg;
    acc_t                 acc_a_reg;
    x_t                   x_a_reg;
    logic signed [64:0]   p_hi_next;
    logic        [63:0]   p_lo_next;

    logic                 vb_reg;
    acc_t                 acc_b_reg;
    x_t                   x_b_reg;
    acc_t                 acc_b_next;

    // stage A: two 32x32 partial products
    always_comb
    begin
        p_hi_next = $signed(in_acc[63:32]) * $signed({1'b0, in_x[31:0]});
        p_lo_next = {32'd0, in_acc[31:0]} * {32'd0, in_x[31:0]};
    end

    // stage B: combine, add the x == 1.0 term and the coefficient
    always_comb
    begin
        acc_b_next = p_hi_reg[63:0] + {32'd0, p_lo_reg[63:32]}
                   + (x_a_reg[32] ? acc_a_reg : '0) + coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg  <= p_hi_next;
        p_lo_reg  <= p_lo_next;
        acc_a_reg <= in_acc;
        x_a_reg   <= in_x;
        acc_b_reg <= acc_b_next;
        x_b_reg   <= x_a_reg;
    end

    assign out_valid = vb_reg;
    assign out_acc   = acc_b_reg;
    assign out_x     = x_b_reg;

endmodule

// File: rtl/gop_round.sv
// ----------------------------------------------------------------------------
// gop_round
// Converts the signed accumulator to unsigned Q1.OUT_FRAC_BITS, saturating.
// ----------------------------------------------------------------------------
module gop_round
#(
    parameter int unsigned OUT_FRAC_BITS = 40
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  gop_pkg::acc_t            in_acc,
    output logic                     done,
    output logic [OUT_FRAC_BITS:0]   gamma_value
);
    import gop_pkg::*;

    localparam int unsigned OW = OUT_FRAC_BITS + 1;

    logic          done_reg;
    logic [OW-1:0] val_reg;
    logic [OW-1:0] val_next;

    generate
        if (OUT_FRAC_BITS < COEF_FRAC_BITS)
        begin : g_down
            localparam int unsigned SH = COEF_FRAC_BITS - OUT_FRAC_BITS;
            logic [64:0] sum;
            logic [64:0] q;
            always_comb
            begin
                sum = {1'b0, in_acc} + (65'd1 << (SH - 1));
                q   = sum >> SH;
                if (in_acc[63])
                    val_next = '0;
                else if (q > 65'({OW{1'b1}}))
                    val_next = '1;
                else
                    val_next = q[OW-1:0];
            end
        end
        else
        begin : g_up
            localparam int unsigned SH = OUT_FRAC_BITS - COEF_FRAC_BITS;
            logic [OW-1:0] lim;
            always_comb
            begin
                lim = {OW{1'b1}} >> SH;
                if (in_acc[63])
                    val_next = '0;
                else if (OW'(in_acc) > lim || (in_acc >> OW) != 64'd0)
                    val_next = '1;
                else
                    val_next = OW'(in_acc) << SH;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign done        = done_reg;
    assign gamma_value = val_reg;

endmodule

// File: rtl/gamma_one_plus_x_polynomial.sv
// ----------------------------------------------------------------------------
// gamma_one_plus_x_polynomial
// Gamma(1+x) for x in [0,1] by a fixed degree TERM_COUNT-1 polynomial,
// evaluated by Horner's rule in a fully pipelined 64-bit datapath.
// ----------------------------------------------------------------------------
// Usage: drive x_frac (Q1.32, 2^32 = 1.0; larger values clamp to 1.0) and
// pulse start. busy is always low, so a new beat may be issued on every
// clock. Each beat returns exactly one result, in issue order, on
// gamma_value (unsigned Q1.OUT_FRAC_BITS, saturating) with done high for a
// single cycle. The depth is set by the Horner chain: each step is one
// split 64x33 multiply (two 32x32 partial products) registered, then one
// add stage, plus the entry and result registers. There is no output
// buffering: the receiver must take each result in the cycle it is
// presented.
// ----------------------------------------------------------------------------
module gamma_one_plus_x_polynomial
#(
    parameter int unsigned TERM_COUNT    = 30,
    parameter int unsigned OUT_FRAC_BITS = 40
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  gop_pkg::x_t            x_frac,
    output logic                   done,
    output logic [OUT_FRAC_BITS:0] gamma_value
);
    import gop_pkg::*;

    localparam int unsigned STEPS = TERM_COUNT - 1;
    localparam x_t          X_ONE = x_t'(64'd1 << 32);

    // Entry register: clamp the argument, seed with the top coefficient
    logic v0_reg;
    x_t   x0_reg;
    x_t   x0_next;

    logic v_pipe   [STEPS+1];
    acc_t acc_pipe [STEPS+1];
    x_t   x_pipe   [STEPS+1];

    assign x0_next = (x_frac > X_ONE) ? X_ONE : x_frac;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next;
    end

    assign v_pipe[0]   = v0_reg;
    assign acc_pipe[0] = COEF[TERM_COUNT-1];
    assign x_pipe[0]   = x0_reg;

    // Horner chain, highest coefficient first
    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            gop_step u_step
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v_pipe[k]),
                .in_acc    (acc_pipe[k]),
                .in_x      (x_pipe[k]),
                .coef      (COEF[TERM_COUNT-2-k]),
                .out_valid (v_pipe[k+1]),
                .out_acc   (acc_pipe[k+1]),
                .out_x     (x_pipe[k+1])
            );
        end
    endgenerate

    // Output conversion and result register
    gop_round #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_round
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v_pipe[STEPS]),
        .in_acc      (acc_pipe[STEPS]),
        .done        (done),
        .gamma_value (gamma_value)
    );

    // Pipeline never stalls
    assign busy = 1'b0;

endmodule
